>>> hw/rtl/bbc_pkg.sv
// Shared types and constants for the clipped 3x3 box mean.
package bbc_pkg;

	localparam int PIX_W      = 16;
	localparam int ROW_W      = 16;
	localparam int COL_W      = 10;
	localparam int COLS_CFG_W = 11;
	localparam int LINE_DEPTH = 1024;
	localparam int ADDR_W     = $clog2(LINE_DEPTH);
	localparam int LINE_W     = 2 * PIX_W;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Row sum of three pixels, total of nine pixels.
	localparam int ROWSUM_W = PIX_W + 2;
	localparam int SUM_W    = PIX_W + 4;

	// Reciprocal constants: floor(s/3) = (s*M3) >> SHIFT3, floor(s/9) = (s*M9) >> SHIFT9,
	// exact for every s below 2**SUM_W.
	localparam int SHIFT3 = SUM_W + 1;
	localparam int SHIFT9 = SUM_W + 4;
	localparam int MUL_W  = SUM_W + 1;
	localparam logic [MUL_W-1:0] M3 = MUL_W'(((64'd1 << SHIFT3) + 64'd2) / 64'd3);
	localparam logic [MUL_W-1:0] M9 = MUL_W'(((64'd1 << SHIFT9) + 64'd8) / 64'd9);
	localparam int PROD_W = SUM_W + MUL_W;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS = CFG_IDX_W'(1);

	typedef logic [8:0][PIX_W-1:0] window_t;

	typedef enum logic [2:0] {
		DIV1,
		DIV2,
		DIV3,
		DIV4,
		DIV6,
		DIV9
	} div_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_UPDATE,
		ST_START,
		ST_WAIT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic       start;
		logic [2:0] row_mask;
		logic [2:0] col_mask;
	} mean_req_t;

	typedef struct packed {
		logic             done;
		logic [PIX_W-1:0] mean;
	} mean_rsp_t;

endpackage

>>> hw/rtl/box_blur_3x3_clipped.sv
// Clipped 3x3 box mean over a raster pixel stream, two line stores in one memory.
// A pixel is accepted only in IDLE; it then passes READ (line store read) and UPDATE
// (window update), then START, WAIT and EMIT for each of its 0 to 4 results, set by the
// sequencer sharing one sum/divide unit. EMIT waits while the result output is held.
// Reset: image_rows = image_cols = 1, position and window cleared; the line store
// contents are undefined until written and need no clearing pass.
module box_blur_3x3_clipped (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [bbc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bbc_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             pix_valid,
	output logic                             pix_ready,
	input  logic [bbc_pkg::PIX_W-1:0]        pixel_in,
	output logic                             res_valid,
	input  logic                             res_ready,
	output logic [bbc_pkg::PIX_W-1:0]        pixel_out,
	output logic [bbc_pkg::ROW_W-1:0]        out_row,
	output logic [bbc_pkg::COL_W-1:0]        out_col,
	output logic                             last_of_run,
	output logic                             frame_done
);

	bbc_pkg::state_t state_q, state_d;

	logic [bbc_pkg::ROW_W-1:0]      rows_q;
	logic [bbc_pkg::COLS_CFG_W-1:0] cols_q;
	logic [bbc_pkg::ROW_W-1:0]      row_cnt_q;
	logic [bbc_pkg::COL_W-1:0]      col_cnt_q;
	logic [bbc_pkg::ROW_W-1:0]      rows_m1;
	logic [bbc_pkg::COLS_CFG_W-1:0] cols_eff;
	logic [bbc_pkg::COL_W-1:0]      cols_m1;
	logic [bbc_pkg::ROW_W-1:0]      r_in;
	logic [bbc_pkg::COL_W-1:0]      c_in;
	logic                           cfg_hit;
	logic                           pix_xfer;

	logic [bbc_pkg::PIX_W-1:0]      pix_q;
	logic [bbc_pkg::ROW_W-1:0]      r_q;
	logic [bbc_pkg::COL_W-1:0]      c_q;
	logic                           last_row_q, last_col_q;
	logic                           row_prev_q, col_prev_q;
	bbc_pkg::window_t               win_q;

	logic                           rd_en, wr_en;
	logic [bbc_pkg::LINE_W-1:0]     rd_data, wr_data;

	bbc_pkg::mean_req_t             mreq;
	bbc_pkg::mean_rsp_t             mrsp;

	logic                           has_results;
	logic                           run_last;
	logic                           load_out;
	logic                           out_free;
	logic                           r_ge1, r_ge2, c_ge1, c_ge2;

	// effective image size, clamped position, config hit and pixel transfer
	always_comb begin
		rows_m1  = (rows_q == '0) ? '0 : rows_q - 1'b1;
		if (cols_q == '0) begin
			cols_eff = bbc_pkg::COLS_CFG_W'(1);
		end else if (cols_q > bbc_pkg::COLS_CFG_W'(bbc_pkg::LINE_DEPTH)) begin
			cols_eff = bbc_pkg::COLS_CFG_W'(bbc_pkg::LINE_DEPTH);
		end else begin
			cols_eff = cols_q;
		end
		cols_m1  = bbc_pkg::COL_W'(cols_eff - 1'b1);
		r_in     = (row_cnt_q > rows_m1) ? rows_m1 : row_cnt_q;
		c_in     = (col_cnt_q > cols_m1) ? cols_m1 : col_cnt_q;
		cfg_hit  = cfg_we && (cfg_index == bbc_pkg::REG_IMAGE_ROWS
			|| cfg_index == bbc_pkg::REG_IMAGE_COLS);
		pix_xfer = pix_valid && pix_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q    <= bbc_pkg::ROW_W'(1);
			cols_q    <= bbc_pkg::COLS_CFG_W'(1);
			row_cnt_q <= '0;
			col_cnt_q <= '0;
		end else if (cfg_hit) begin
			if (cfg_index == bbc_pkg::REG_IMAGE_ROWS) begin
				rows_q <= cfg_data[bbc_pkg::ROW_W-1:0];
			end else begin
				cols_q <= cfg_data[bbc_pkg::COLS_CFG_W-1:0];
			end
			row_cnt_q <= '0;
			col_cnt_q <= '0;
		end else if (pix_xfer) begin
			if (c_in == cols_m1) begin
				col_cnt_q <= '0;
				row_cnt_q <= (r_in == rows_m1) ? '0 : r_in + 1'b1;
			end else begin
				col_cnt_q <= c_in + 1'b1;
			end
		end
	end

	// result enumeration helpers and output free flag
	always_comb begin
		r_ge1       = (r_q != '0);
		r_ge2       = (r_q > bbc_pkg::ROW_W'(1));
		c_ge1       = (c_q != '0);
		c_ge2       = (c_q > bbc_pkg::COL_W'(1));
		has_results = (r_ge1 || last_row_q) && (c_ge1 || last_col_q);
		run_last    = !(col_prev_q && last_col_q) && !(row_prev_q && last_row_q);
		out_free    = !res_valid || res_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bbc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		pix_ready     = 1'b0;
		rd_en         = 1'b0;
		wr_en         = 1'b0;
		load_out      = 1'b0;
		mreq.start    = 1'b0;
		mreq.row_mask = row_prev_q ? {1'b1, 1'b1, r_ge2} : {1'b1, r_ge1, 1'b0};
		mreq.col_mask = col_prev_q ? {1'b1, 1'b1, c_ge2} : {1'b1, c_ge1, 1'b0};
		unique case (state_q)
			bbc_pkg::ST_IDLE: begin
				pix_ready = 1'b1;
				if (pix_valid) begin
					state_d = bbc_pkg::ST_READ;
				end
			end
			bbc_pkg::ST_READ: begin
				rd_en   = 1'b1;
				state_d = bbc_pkg::ST_UPDATE;
			end
			bbc_pkg::ST_UPDATE: begin
				wr_en   = 1'b1;
				state_d = has_results ? bbc_pkg::ST_START : bbc_pkg::ST_IDLE;
			end
			bbc_pkg::ST_START: begin
				mreq.start = 1'b1;
				state_d    = bbc_pkg::ST_WAIT;
			end
			bbc_pkg::ST_WAIT: begin
				if (mrsp.done) begin
					state_d = bbc_pkg::ST_EMIT;
				end
			end
			bbc_pkg::ST_EMIT: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = run_last ? bbc_pkg::ST_IDLE : bbc_pkg::ST_START;
				end
			end
			default: state_d = bbc_pkg::ST_IDLE;
		endcase
	end

	// two above takes the old row above, row above takes the new pixel
	assign wr_data = {rd_data[bbc_pkg::PIX_W-1:0], pix_q};

	bbc_line_ram u_line_ram (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (c_q),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (c_q),
		.wr_data (wr_data)
	);

	bbc_mean u_mean (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.win    (win_q),
		.rsp    (mrsp)
	);

	always_ff @(posedge clk) begin
		if (pix_xfer) begin
			pix_q      <= pixel_in;
			r_q        <= r_in;
			c_q        <= c_in;
			last_row_q <= (r_in == rows_m1);
			last_col_q <= (c_in == cols_m1);
		end
		if (wr_en) begin
			row_prev_q <= r_ge1;
			col_prev_q <= c_ge1;
		end else if (load_out) begin
			// step columns first, then rows
			if (col_prev_q && last_col_q) begin
				col_prev_q <= 1'b0;
			end else begin
				col_prev_q <= c_ge1;
				row_prev_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (wr_en) begin
			for (int k = 0; k < 3; k++) begin
				win_q[k*3]   <= win_q[k*3+1];
				win_q[k*3+1] <= win_q[k*3+2];
			end
			win_q[2] <= rd_data[bbc_pkg::LINE_W-1:bbc_pkg::PIX_W];
			win_q[5] <= rd_data[bbc_pkg::PIX_W-1:0];
			win_q[8] <= pix_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (load_out) begin
			res_valid <= 1'b1;
		end else if (res_ready) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			pixel_out   <= mrsp.mean;
			out_row     <= row_prev_q ? r_q - 1'b1 : r_q;
			out_col     <= col_prev_q ? c_q - 1'b1 : c_q;
			last_of_run <= run_last;
			frame_done  <= !row_prev_q && last_row_q && !col_prev_q && last_col_q;
		end
	end

endmodule

>>> hw/rtl/bbc_line_ram.sv
// Line store memory: both previous rows of one column in one word, registered read.
module bbc_line_ram (
	input  logic                         clk,
	input  logic                         rd_en,
	input  logic [bbc_pkg::ADDR_W-1:0]   rd_addr,
	output logic [bbc_pkg::LINE_W-1:0]   rd_data,
	input  logic                         wr_en,
	input  logic [bbc_pkg::ADDR_W-1:0]   wr_addr,
	input  logic [bbc_pkg::LINE_W-1:0]   wr_data
);

	logic [bbc_pkg::LINE_W-1:0] mem [bbc_pkg::LINE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> hw/rtl/bbc_mean.sv
// Masked window sum and truncating division by the in-image pixel count.
module bbc_mean (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bbc_pkg::mean_req_t   req,
	input  bbc_pkg::window_t     win,
	output bbc_pkg::mean_rsp_t   rsp
);

	logic [2:0][bbc_pkg::ROWSUM_W-1:0] rsum;
	logic [1:0]                        rcnt, ccnt;
	logic [3:0]                        npix;
	bbc_pkg::div_t                     div_c;

	logic                              v_s1, v_s2, v_s3;
	logic [2:0][bbc_pkg::ROWSUM_W-1:0] rsum_s1;
	bbc_pkg::div_t                     div_s1, div_s2, div_s3;
	logic [bbc_pkg::SUM_W-1:0]         total_s2, total_s3;
	logic [bbc_pkg::SUM_W-1:0]         operand;
	logic [bbc_pkg::MUL_W-1:0]         recip;
	logic [bbc_pkg::PROD_W-1:0]        prod_s3;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			rsum[k] = '0;
			for (int m = 0; m < 3; m++) begin
				if (req.row_mask[k] && req.col_mask[m]) begin
					rsum[k] = rsum[k] + bbc_pkg::ROWSUM_W'(win[k*3+m]);
				end
			end
		end
		rcnt = 2'({1'b0, req.row_mask[0]}) + 2'({1'b0, req.row_mask[1]})
			+ 2'({1'b0, req.row_mask[2]});
		ccnt = 2'({1'b0, req.col_mask[0]}) + 2'({1'b0, req.col_mask[1]})
			+ 2'({1'b0, req.col_mask[2]});
		npix = 4'(rcnt) * 4'(ccnt);
		unique case (npix)
			4'd2:    div_c = bbc_pkg::DIV2;
			4'd3:    div_c = bbc_pkg::DIV3;
			4'd4:    div_c = bbc_pkg::DIV4;
			4'd6:    div_c = bbc_pkg::DIV6;
			4'd9:    div_c = bbc_pkg::DIV9;
			default: div_c = bbc_pkg::DIV1;
		endcase
	end

	// /6 is /2 then /3; /9 has its own reciprocal
	always_comb begin
		operand = (div_s2 == bbc_pkg::DIV6) ? (total_s2 >> 1) : total_s2;
		recip   = (div_s2 == bbc_pkg::DIV9) ? bbc_pkg::M9 : bbc_pkg::M3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= req.start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rsum_s1 <= rsum;
			div_s1  <= div_c;
		end
		if (v_s1) begin
			total_s2 <= bbc_pkg::SUM_W'(rsum_s1[0]) + bbc_pkg::SUM_W'(rsum_s1[1])
				+ bbc_pkg::SUM_W'(rsum_s1[2]);
			div_s2   <= div_s1;
		end
		if (v_s2) begin
			prod_s3  <= bbc_pkg::PROD_W'(operand) * bbc_pkg::PROD_W'(recip);
			total_s3 <= total_s2;
			div_s3   <= div_s2;
		end
	end

	always_comb begin
		rsp.done = v_s3;
		unique case (div_s3)
			bbc_pkg::DIV1: rsp.mean = bbc_pkg::PIX_W'(total_s3);
			bbc_pkg::DIV2: rsp.mean = bbc_pkg::PIX_W'(total_s3 >> 1);
			bbc_pkg::DIV4: rsp.mean = bbc_pkg::PIX_W'(total_s3 >> 2);
			bbc_pkg::DIV3,
			bbc_pkg::DIV6: rsp.mean = bbc_pkg::PIX_W'(prod_s3 >> bbc_pkg::SHIFT3);
			bbc_pkg::DIV9: rsp.mean = bbc_pkg::PIX_W'(prod_s3 >> bbc_pkg::SHIFT9);
			default:       rsp.mean = '0;
		endcase
	end

endmodule
